@@ src/nops_pkg.sv @@
// Shared types and constants of the nearest-obstacle steering block.
// Holds the configuration struct, the scan record, state codes and CORDIC tables.
// No dependencies.
package nops_pkg;

    // Scan tracking
    localparam logic [16:0] RANGE_START = 17'd101376;   // 99 m in 1/1024 m

    // CORDIC constants, Q2.30
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);
    localparam logic [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [29:0] KINV_Q30    = 30'd652032874;
    localparam int GUARD_BITS = 8;

    // Division by 5: floor(a * 52429 / 2^18) is exact for a below 2^18
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int DIV5_SHIFT = 18;

    // Configuration register map
    typedef enum logic [1:0] {
        REG_START_ANGLE,
        REG_ANGLE_STEP,
        REG_DRIVE_ENABLE,
        REG_STOP_DISTANCE
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] start_angle;
        logic [13:0] angle_step;
        logic        drive_enable;
        logic [16:0] stop_distance;
    } cfg_t;

    // One finished scan, handed from front to back
    typedef struct packed {
        logic [16:0]        min_range;
        logic signed [15:0] best_angle;
    } scan_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MULT,
        BK_ROTATE,
        BK_ROUND,
        BK_SCALE,
        BK_EMIT
    } back_state_t;

    // Q2.30 constant rounded half up to the angle format
    function automatic logic [31:0] q30_to_angle(input logic [31:0] c, input int frac);
        int          s;
        logic [32:0] sum;
        s   = 30 - frac;
        sum = {1'b0, c} + (33'd1 << (s - 1));
        return 32'(sum >> s);
    endfunction

endpackage

@@ src/nops_front.sv @@
// Front end: accepts range samples, tracks the nearest point of the scan.
// Pushes one scan record into the queue on the last sample.
// Depends on nops_pkg.
module nops_front
    import nops_pkg::*;
#(
    parameter int RANGE_BITS = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        push,
    input  logic [16:0] range_sample,
    input  logic        last_sample,
    input  logic        q_full,
    output logic        q_push,
    output scan_t       q_data
);

    localparam int RB = (RANGE_BITS < 17) ? RANGE_BITS : 17;
    localparam logic [17:0] RANGE_MASK = (18'd1 << RB) - 18'd1;

    logic [16:0]        min_range_reg, min_range_next;
    logic signed [15:0] best_angle_reg, best_angle_next;
    logic signed [17:0] beam_angle_reg, beam_angle_next;
    logic               in_scan_reg, in_scan_next;

    logic               accept;
    logic [16:0]        r;
    logic [16:0]        cur_min;
    logic signed [17:0] cur_angle;
    logic signed [15:0] cur_angle_sat;
    logic signed [18:0] beam_sum;

    assign accept = push & ~q_full;

    // Per-sample update
    always_comb
    begin
        r         = range_sample & RANGE_MASK[16:0];
        cur_min   = in_scan_reg ? min_range_reg : RANGE_START;
        cur_angle = in_scan_reg ? beam_angle_reg
                                : {{2{cfg.start_angle[15]}}, cfg.start_angle};

        if (cur_angle > 18'sd32767)
            cur_angle_sat = 16'sh7FFF;
        else if (cur_angle < -18'sd32768)
            cur_angle_sat = -16'sh8000;
        else
            cur_angle_sat = cur_angle[15:0];

        beam_sum = {cur_angle[17], cur_angle} + $signed({5'b0, cfg.angle_step});

        min_range_next  = min_range_reg;
        best_angle_next = best_angle_reg;
        beam_angle_next = beam_angle_reg;
        in_scan_next    = in_scan_reg;
        if (accept)
        begin
            min_range_next = cur_min;
            if (r < cur_min)
            begin
                min_range_next  = r;
                best_angle_next = cur_angle_sat;
            end
            // saturate the beam angle to 18 bits
            if (beam_sum[18] != beam_sum[17])
                beam_angle_next = beam_sum[18] ? {1'b1, 17'd0} : {1'b0, {17{1'b1}}};
            else
                beam_angle_next = beam_sum[17:0];
            in_scan_next = ~last_sample;
        end
    end

    assign q_push            = accept & last_sample;
    assign q_data.min_range  = min_range_next;
    assign q_data.best_angle = best_angle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg  <= RANGE_START;
            best_angle_reg <= '0;
            beam_angle_reg <= '0;
            in_scan_reg    <= 1'b0;
        end
        else
        begin
            min_range_reg  <= min_range_next;
            best_angle_reg <= best_angle_next;
            beam_angle_reg <= beam_angle_next;
            in_scan_reg    <= in_scan_next;
        end
    end

endmodule

@@ src/nops_queue.sv @@
// Two-entry queue of finished scan records between front and back end.
// Depends on nops_pkg.
module nops_queue
    import nops_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  scan_t wr_data,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output scan_t rd_data
);

    scan_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ src/nops_back.sv @@
// Back end: CORDIC rotation of the nearest point, rounding and drive gains.
// Holds the result register seen on the output ports.
// Depends on nops_pkg.
module nops_back
    import nops_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS   = 13,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  scan_t              q_data,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [17:0] point_x,
    output logic signed [17:0] point_y,
    output logic signed [15:0] speed_x,
    output logic signed [15:0] speed_y,
    output logic signed [15:0] turn_rate
);

    localparam int ITER_N  = (CORDIC_ITERATIONS < ATAN_DEPTH) ? CORDIC_ITERATIONS
                                                              : ATAN_DEPTH;
    localparam int ITER_W  = $clog2(ITER_N);
    localparam int THETA_W = 20;
    localparam int XY_W    = 27;
    localparam int PW      = XY_W - GUARD_BITS + 1;

    localparam logic signed [THETA_W-1:0] PI_A =
        THETA_W'(q30_to_angle(PI_Q30, ANGLE_FRAC_BITS));
    localparam logic signed [THETA_W-1:0] HALF_PI_A =
        THETA_W'(q30_to_angle(HALF_PI_Q30, ANGLE_FRAC_BITS));
    localparam logic signed [XY_W-1:0] RND = XY_W'(1 << (GUARD_BITS - 1));
    localparam logic signed [PW-1:0]   PMAX_W = PW'(131071);

    back_state_t         state_reg, state_next;
    logic [16:0]         min_reg, min_next;
    logic signed [15:0]  best_reg, best_next;
    logic signed [THETA_W-1:0] theta_reg, theta_next;
    logic                flip_reg, flip_next;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic signed [17:0]  px_reg, px_next, py_reg, py_next;
    logic [15:0]         qx_reg, qx_next, qy_reg, qy_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [17:0]  out_px_reg, out_px_next, out_py_reg, out_py_next;
    logic signed [15:0]  out_sx_reg, out_sx_next, out_sy_reg, out_sy_next;
    logic signed [15:0]  out_tr_reg, out_tr_next;

    logic signed [THETA_W-1:0] best_w, atan_a;
    logic [46:0]         scale_prod;
    logic signed [XY_W-1:0] dx, dy, x_rnd, y_rnd, x_sh, y_sh;
    logic signed [PW-1:0] px_w, py_w, px_f, py_f;
    logic [17:0]         ax, ay;
    logic [33:0]         prod_x, prod_y;
    logic                out_free, drive_go;

    // Combinational helpers for the arithmetic steps
    always_comb
    begin
        best_w     = THETA_W'(q_data.best_angle);
        scale_prod = min_reg * KINV_Q30;
        dx         = y_reg >>> iter_reg;
        dy         = x_reg >>> iter_reg;
        atan_a     = THETA_W'(q30_to_angle(ATAN_Q30[ATAN_IDX_W'(iter_reg)], ANGLE_FRAC_BITS));

        x_rnd = x_reg + RND;
        y_rnd = y_reg + RND;
        x_sh  = x_rnd >>> GUARD_BITS;
        y_sh  = y_rnd >>> GUARD_BITS;
        px_w  = PW'(x_sh);
        py_w  = PW'(y_sh);
        px_f  = flip_reg ? -px_w : px_w;
        py_f  = flip_reg ? -py_w : py_w;

        ax     = (px_reg[17] ? 18'(-px_reg) : 18'(px_reg)) + 18'd2;
        ay     = (py_reg[17] ? 18'(-py_reg) : 18'(py_reg)) + 18'd2;
        prod_x = ax * DIV5_RECIP;
        prod_y = ay * DIV5_RECIP;

        drive_go = cfg.drive_enable &&
                   ($signed({px_reg[17], px_reg}) > $signed({2'b00, cfg.stop_distance}));
        out_free = ~out_valid_reg | pop;
    end

    // Sequencer: next state and datapath register updates
    always_comb
    begin
        state_next     = state_reg;
        min_next       = min_reg;
        best_next      = best_reg;
        theta_next     = theta_reg;
        flip_next      = flip_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        iter_next      = iter_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        out_sx_next    = out_sx_reg;
        out_sy_next    = out_sy_reg;
        out_tr_next    = out_tr_reg;
        out_valid_next = out_valid_reg & ~pop;
        q_pop          = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    min_next  = q_data.min_range;
                    best_next = q_data.best_angle;
                    // fold angles beyond +-pi/2 by pi
                    if (best_w > HALF_PI_A)
                    begin
                        theta_next = best_w - PI_A;
                        flip_next  = 1'b1;
                    end
                    else if (best_w < -HALF_PI_A)
                    begin
                        theta_next = best_w + PI_A;
                        flip_next  = 1'b1;
                    end
                    else
                    begin
                        theta_next = best_w;
                        flip_next  = 1'b0;
                    end
                    state_next = BK_MULT;
                end
            end
            BK_MULT:
            begin
                // range times 1/gain, keeping the guard bits
                x_next     = XY_W'(scale_prod >> (30 - GUARD_BITS));
                y_next     = '0;
                iter_next  = '0;
                state_next = BK_ROTATE;
            end
            BK_ROTATE:
            begin
                if (theta_reg >= 0)
                begin
                    x_next     = x_reg - dx;
                    y_next     = y_reg + dy;
                    theta_next = theta_reg - atan_a;
                end
                else
                begin
                    x_next     = x_reg + dx;
                    y_next     = y_reg - dy;
                    theta_next = theta_reg + atan_a;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ITER_N - 1))
                    state_next = BK_ROUND;
            end
            BK_ROUND:
            begin
                if (px_f > PMAX_W)
                    px_next = 18'sd131071;
                else if (px_f < -PMAX_W)
                    px_next = -18'sd131071;
                else
                    px_next = 18'(px_f);
                if (py_f > PMAX_W)
                    py_next = 18'sd131071;
                else if (py_f < -PMAX_W)
                    py_next = -18'sd131071;
                else
                    py_next = 18'(py_f);
                state_next = BK_SCALE;
            end
            BK_SCALE:
            begin
                // magnitude divided by 5, rounded half away from zero
                qx_next    = 16'(prod_x >> DIV5_SHIFT);
                qy_next    = 16'(prod_y >> DIV5_SHIFT);
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_px_next    = px_reg;
                    out_py_next    = py_reg;
                    if (drive_go)
                    begin
                        out_sx_next = px_reg[17] ? -$signed(qx_reg) : $signed(qx_reg);
                        out_sy_next = py_reg[17] ? -$signed(qy_reg) : $signed(qy_reg);
                        out_tr_next = (best_reg == -16'sh8000) ? 16'sh7FFF : -best_reg;
                    end
                    else
                    begin
                        out_sx_next = '0;
                        out_sy_next = '0;
                        out_tr_next = '0;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        min_reg    <= min_next;
        best_reg   <= best_next;
        theta_reg  <= theta_next;
        flip_reg   <= flip_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        iter_reg   <= iter_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        out_px_reg <= out_px_next;
        out_py_reg <= out_py_next;
        out_sx_reg <= out_sx_next;
        out_sy_reg <= out_sy_next;
        out_tr_reg <= out_tr_next;
    end

    assign empty     = ~out_valid_reg;
    assign point_x   = out_px_reg;
    assign point_y   = out_py_reg;
    assign speed_x   = out_sx_reg;
    assign speed_y   = out_sy_reg;
    assign turn_rate = out_tr_reg;

endmodule

@@ src/nearest_obstacle_p_steer.sv @@
// Top level of the nearest-obstacle steering block: register port and wiring.
// Depends on nops_pkg, nops_front, nops_queue and nops_back.
//
// Range samples enter through a queue-style port at one sample per cycle
// unless full is high. The sample flagged last closes the scan; its nearest
// point is handed to a two-entry queue and the back end converts it into x/y
// and drive commands, one CORDIC iteration per cycle on a single shift-add
// unit. full rises when two finished scans are waiting on the back end, and
// then stalls every sample, inside a scan or not. While results are popped
// promptly, scans as long in samples as a back-end pass never see a stall. A
// result sits in the output register until popped while the back end already
// works on the next scan. Registers are written over the APB port at byte
// offsets 0, 4, 8, 12; the start angle applies from the next scan start.
module nearest_obstacle_p_steer
    import nops_pkg::*;
#(
    parameter int RANGE_BITS        = 17,
    parameter int ANGLE_FRAC_BITS   = 13,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // samples
    input  logic               push,
    output logic               full,
    input  logic [16:0]        range_sample,
    input  logic               last_sample,
    // results
    output logic               empty,
    input  logic               pop,
    output logic signed [17:0] point_x,
    output logic signed [17:0] point_y,
    output logic signed [15:0] speed_x,
    output logic signed [15:0] speed_y,
    output logic signed [15:0] turn_rate
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_write;

    logic     q_push, q_pop, q_full, q_empty;
    scan_t    q_wr_data, q_rd_data;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_START_ANGLE:   cfg_next.start_angle   = pwdata[15:0];
                REG_ANGLE_STEP:    cfg_next.angle_step    = pwdata[13:0];
                REG_DRIVE_ENABLE:  cfg_next.drive_enable  = pwdata[0];
                REG_STOP_DISTANCE: cfg_next.stop_distance = pwdata[16:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_START_ANGLE:   prdata = {16'd0, cfg_reg.start_angle};
            REG_ANGLE_STEP:    prdata = {18'd0, cfg_reg.angle_step};
            REG_DRIVE_ENABLE:  prdata = {31'd0, cfg_reg.drive_enable};
            REG_STOP_DISTANCE: prdata = {15'd0, cfg_reg.stop_distance};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle   <= 16'(-25736);
            cfg_reg.angle_step    <= 14'd48;
            cfg_reg.drive_enable  <= 1'b0;
            cfg_reg.stop_distance <= 17'd512;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full = q_full;

    nops_front #(
        .RANGE_BITS (RANGE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .range_sample (range_sample),
        .last_sample  (last_sample),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wr_data)
    );

    nops_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .rd_data (q_rd_data)
    );

    nops_back #(
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .point_x   (point_x),
        .point_y   (point_y),
        .speed_x   (speed_x),
        .speed_y   (speed_y),
        .turn_rate (turn_rate)
    );

endmodule

@@ src/nops_checker.sv @@
// Port-level checks for the nearest-obstacle steering block.
// Bound to nearest_obstacle_p_steer; no other dependencies.
module nops_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [17:0] point_x,
    input logic signed [17:0] point_y,
    input logic signed [15:0] speed_x,
    input logic signed [15:0] speed_y,
    input logic signed [15:0] turn_rate
);

    // A waiting item holds until it is popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(point_x) && $stable(point_y) &&
                              $stable(speed_x) && $stable(speed_y) && $stable(turn_rate)))
        else $error("result item changed while stalled");

    // No item is shown during reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // Any drive command needs an obstacle ahead
    a_drive_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (speed_x != 16'sd0 || speed_y != 16'sd0 || turn_rate != 16'sd0))
        |-> (point_x > 18'sd0))
        else $error("drive command with point_x not ahead");

    // Lateral speed follows the sign of the lateral coordinate
    a_lateral_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && speed_y != 16'sd0) |-> (speed_y[15] == point_y[17]))
        else $error("speed_y sign disagrees with point_y");

endmodule

bind nearest_obstacle_p_steer nops_checker u_nops_checker (.*);
